FILE: rtl/spt_pkg.sv
package spt_pkg;

  // parameter defaults
  localparam int unsigned TABLE_DEPTH_DEF = 256;
  localparam int unsigned ID_WIDTH_DEF    = 16;
  localparam int unsigned MAX_FOUND_DEF   = 64;

  // fixed field widths on the ports
  localparam int unsigned ID_W    = 16;
  localparam int unsigned LIMIT_W = 7;
  localparam int unsigned INDEX_W = 7;

  typedef enum logic {
    CMD_DECLARE = 1'b0,
    CMD_FIND    = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_DECLARE = 2'd0,
    KIND_PARTNER = 2'd1,
    KIND_EMPTY   = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    DECL_ADDED   = 2'd0,
    DECL_PRESENT = 2'd1,
    DECL_FULL    = 2'd2
  } decl_status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECL_DUP,
    S_DECL_END,
    S_FIND_END
  } ctrl_state_e;

  // controller -> datapath
  typedef struct packed {
    logic         load;
    logic         step;
    logic         take_hit;
    logic         emit_decl;
    decl_status_e decl_status;
    logic         write_entry;
    logic         emit_final;
  } spt_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_find;
    logic cmp_valid;
    logic hit;
    logic scan_done;
    logic limit_hit;
    logic out_free;
    logic full;
    logic pend_valid;
  } spt_sts_t;

endpackage

FILE: rtl/spt_ctrl.sv
module spt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  spt_pkg::spt_sts_t sts_i,
  output spt_pkg::spt_cmd_t cmd_o
);
  import spt_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_SCAN;
      end
      S_SCAN: begin
        if (sts_i.is_find) begin
          if (sts_i.limit_hit) begin
            state_d = S_FIND_END;
          end else if (!(sts_i.cmp_valid && sts_i.hit) && sts_i.scan_done) begin
            state_d = S_FIND_END;
          end
        end else begin
          if (sts_i.cmp_valid && sts_i.hit) begin
            state_d = S_DECL_DUP;
          end else if (sts_i.scan_done) begin
            state_d = S_DECL_END;
          end
        end
      end
      S_DECL_DUP, S_DECL_END, S_FIND_END: begin
        if (sts_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o = '0;
    cmd_o.decl_status = DECL_ADDED;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      S_SCAN: begin
        if (sts_i.is_find) begin
          if (!sts_i.limit_hit) begin
            if (sts_i.cmp_valid && sts_i.hit) begin
              // a new match pushes the held one out; wait if the output is busy
              if (!sts_i.pend_valid || sts_i.out_free) begin
                cmd_o.take_hit = 1'b1;
                cmd_o.step     = 1'b1;
              end
            end else if (!sts_i.scan_done) begin
              cmd_o.step = 1'b1;
            end
          end
        end else begin
          if (!(sts_i.cmp_valid && sts_i.hit) && !sts_i.scan_done) begin
            cmd_o.step = 1'b1;
          end
        end
      end
      S_DECL_DUP: begin
        cmd_o.emit_decl   = sts_i.out_free;
        cmd_o.decl_status = DECL_PRESENT;
      end
      S_DECL_END: begin
        cmd_o.emit_decl   = sts_i.out_free;
        cmd_o.decl_status = sts_i.full ? DECL_FULL : DECL_ADDED;
        cmd_o.write_entry = sts_i.out_free && !sts_i.full;
      end
      S_FIND_END: begin
        cmd_o.emit_final = sts_i.out_free;
      end
      default: ;
    endcase
  end

endmodule

FILE: rtl/spt_dp.sv
module spt_dp #(
  parameter int unsigned TABLE_DEPTH = spt_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned ID_WIDTH    = spt_pkg::ID_WIDTH_DEF,
  parameter int unsigned MAX_FOUND   = spt_pkg::MAX_FOUND_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  spt_pkg::cmd_e               op_i,
  input  logic [spt_pkg::ID_W-1:0]    first_id_i,
  input  logic [spt_pkg::ID_W-1:0]    second_id_i,
  input  logic [spt_pkg::LIMIT_W-1:0] result_limit_i,
  input  spt_pkg::spt_cmd_t           cmd_i,
  output spt_pkg::spt_sts_t           sts_o,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output spt_pkg::kind_e              out_kind_o,
  output logic [1:0]                  out_status_o,
  output logic [spt_pkg::ID_W-1:0]    out_partner_o,
  output logic [spt_pkg::INDEX_W-1:0] out_index_o,
  output logic                        out_last_o
);
  import spt_pkg::*;

  localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned WW = 2 * ID_WIDTH;

  // pair store: {first, second}
  logic [WW-1:0] mem_q [TABLE_DEPTH];
  logic [WW-1:0] rdata_q;

  logic                op_find_q;
  logic [ID_WIDTH-1:0] a_q, b_q;
  logic [LIMIT_W-1:0]  limit_q;
  logic [CW-1:0]       count_q, idx_q;
  logic                cmp_valid_q;
  logic [INDEX_W-1:0]  found_q;
  logic                pend_valid_q;
  logic [ID_WIDTH-1:0] pend_partner_q;
  logic [INDEX_W-1:0]  pend_index_q;

  logic                out_valid_q;
  kind_e               out_kind_q;
  logic [1:0]          out_status_q;
  logic [ID_W-1:0]     out_partner_q;
  logic [INDEX_W-1:0]  out_index_q;
  logic                out_last_q;

  logic [ID_WIDTH-1:0] rd_first, rd_second, hit_partner;
  logic                hit, full, scan_done, rd_en, out_free, push_pend;

  assign rd_first  = rdata_q[WW-1:ID_WIDTH];
  assign rd_second = rdata_q[ID_WIDTH-1:0];
  assign full      = (count_q == CW'(TABLE_DEPTH));
  assign scan_done = !cmp_valid_q && (idx_q == count_q);
  assign rd_en     = cmd_i.step && (idx_q != count_q);
  assign out_free  = !out_valid_q || out_ready_i;
  assign push_pend = cmd_i.take_hit && pend_valid_q;

  always_comb begin
    hit_partner = rd_second;
    if (op_find_q) begin
      if (rd_first == a_q) begin
        hit         = 1'b1;
        hit_partner = rd_second;
      end else if (rd_second == a_q) begin
        hit         = 1'b1;
        hit_partner = rd_first;
      end else begin
        hit = 1'b0;
      end
    end else begin
      hit = ((rd_first == a_q) && (rd_second == b_q)) ||
            ((rd_first == b_q) && (rd_second == a_q));
    end
  end

  assign sts_o.is_find    = op_find_q;
  assign sts_o.cmp_valid  = cmp_valid_q;
  assign sts_o.hit        = hit;
  assign sts_o.scan_done  = scan_done;
  assign sts_o.limit_hit  = (found_q == limit_q);
  assign sts_o.out_free   = out_free;
  assign sts_o.full       = full;
  assign sts_o.pend_valid = pend_valid_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.write_entry) mem_q[count_q[IW-1:0]] <= {a_q, b_q};
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) rdata_q <= mem_q[idx_q[IW-1:0]];
  end

  // item registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_find_q <= (op_i == CMD_FIND);
      a_q       <= ID_WIDTH'(first_id_i);
      b_q       <= ID_WIDTH'(second_id_i);
    end
  end

  // scan control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      idx_q        <= '0;
      cmp_valid_q  <= 1'b0;
      limit_q      <= '0;
      found_q      <= '0;
      pend_valid_q <= 1'b0;
    end else begin
      if (cmd_i.write_entry) count_q <= count_q + CW'(1);
      if (cmd_i.load) begin
        idx_q        <= '0;
        cmp_valid_q  <= 1'b0;
        found_q      <= '0;
        pend_valid_q <= 1'b0;
        limit_q      <= (result_limit_i > LIMIT_W'(MAX_FOUND)) ?
                        LIMIT_W'(MAX_FOUND) : result_limit_i;
      end else begin
        if (cmd_i.step) begin
          cmp_valid_q <= rd_en;
          if (rd_en) idx_q <= idx_q + CW'(1);
        end
        if (cmd_i.take_hit) begin
          pend_valid_q <= 1'b1;
          found_q      <= found_q + INDEX_W'(1);
        end else if (cmd_i.emit_final) begin
          pend_valid_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_hit) begin
      pend_partner_q <= hit_partner;
      pend_index_q   <= found_q + INDEX_W'(1);
    end
  end

  // output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_decl || cmd_i.emit_final || push_pend) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_decl) begin
      out_kind_q    <= KIND_DECLARE;
      out_status_q  <= cmd_i.decl_status;
      out_partner_q <= '0;
      out_index_q   <= '0;
      out_last_q    <= 1'b1;
    end else if (cmd_i.emit_final) begin
      out_kind_q    <= pend_valid_q ? KIND_PARTNER : KIND_EMPTY;
      out_status_q  <= '0;
      out_partner_q <= pend_valid_q ? ID_W'(pend_partner_q) : '0;
      out_index_q   <= pend_valid_q ? pend_index_q : '0;
      out_last_q    <= 1'b1;
    end else if (push_pend) begin
      out_kind_q    <= KIND_PARTNER;
      out_status_q  <= '0;
      out_partner_q <= ID_W'(pend_partner_q);
      out_index_q   <= pend_index_q;
      out_last_q    <= 1'b0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_kind_o    = out_kind_q;
  assign out_status_o  = out_status_q;
  assign out_partner_o = out_partner_q;
  assign out_index_o   = out_index_q;
  assign out_last_o    = out_last_q;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_write_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.write_entry |-> !full)
    else $error("pair written into a full table");

  a_found_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    found_q <= limit_q)
    else $error("more partners found than the limit");

  a_pend_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_valid_q |-> (pend_index_q == found_q))
    else $error("held partner index out of step with found count");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_pend |-> out_free)
    else $error("held partner pushed over an untaken word");
`endif

endmodule

FILE: rtl/symmetric_pair_table_top.sv
// Channel  Dir  tuser         tdata (low bit up)                            tlast
// s_axis   in   cmd[0]        first_id[15:0] second_id[31:16] limit[38:32]  -
// m_axis   out  kind[1:0]     status[1:0] partner_id[17:2] index[24:18]      last
//
// Pairs are read one per cycle from a single-port pair memory, one item in work at a time:
// the next input word is taken only once the last output word of the item has been
// registered.
// A find stops early at its limit, a declare at a matching pair.
// In a find, a stalled output holds the scan at a new match until the word ahead is taken.
// Reset clears the entry count and the control state; the pair memory is not cleared.
module symmetric_pair_table_top #(
  parameter int unsigned TABLE_DEPTH = spt_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned ID_WIDTH    = spt_pkg::ID_WIDTH_DEF,
  parameter int unsigned MAX_FOUND   = spt_pkg::MAX_FOUND_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // first_id, second_id, result_limit, pad
  input  logic        s_axis_tuser,   // cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // status, partner_id, match_index, pad
  output logic [1:0]  m_axis_tuser,   // kind
  output logic        m_axis_tlast    // last
);
  import spt_pkg::*;

  spt_cmd_t           cmd;
  spt_sts_t           sts;
  kind_e              out_kind;
  logic [1:0]         out_status;
  logic [ID_W-1:0]    out_partner;
  logic [INDEX_W-1:0] out_index;

  spt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  spt_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .ID_WIDTH    (ID_WIDTH),
    .MAX_FOUND   (MAX_FOUND)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .op_i           (cmd_e'(s_axis_tuser)),
    .first_id_i     (s_axis_tdata[15:0]),
    .second_id_i    (s_axis_tdata[31:16]),
    .result_limit_i (s_axis_tdata[38:32]),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_ready_i    (m_axis_tready),
    .out_valid_o    (m_axis_tvalid),
    .out_kind_o     (out_kind),
    .out_status_o   (out_status),
    .out_partner_o  (out_partner),
    .out_index_o    (out_index),
    .out_last_o     (m_axis_tlast)
  );

  assign m_axis_tuser = out_kind;
  assign m_axis_tdata = {7'd0, out_index, out_partner, out_status};

endmodule

FILE: sim/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import spt_pkg::*;

  localparam int unsigned DEPTH        = TABLE_DEPTH_DEF;
  localparam int unsigned FOUND_CAP    = MAX_FOUND_DEF;
  localparam int          RANDOM_ITEMS = 385;
  localparam int          IDLE_LIMIT   = 5000;
  localparam int          LONG_HOLD    = 400;
  localparam logic [15:0] HUB_ID       = 16'h5A5A;

  typedef struct packed {
    kind_e        kind;
    decl_status_e status;
    logic [15:0]  partner;
    logic [6:0]   index;
    logic         last;
  } pair_result_t;

  // Holds a shadow copy of the pair table and the result words it implies.
  class pair_scoreboard;
    logic [15:0]  first_tab [DEPTH];
    logic [15:0]  second_tab[DEPTH];
    int           count;
    pair_result_t pending_results[$];
    int           n_added, n_present, n_full, n_find, n_checked, n_errors;

    function int pending();
      return pending_results.size();
    endfunction

    function void note_item(cmd_e cmd, logic [15:0] a, logic [15:0] b, logic [6:0] lim);
      pair_result_t r;
      logic [15:0]  partner;
      int           found;
      int           cap;
      bit           dup;
      if (cmd == CMD_DECLARE) begin
        dup = 0;
        for (int i = 0; i < count; i++) begin
          if ((first_tab[i] == a && second_tab[i] == b) ||
              (first_tab[i] == b && second_tab[i] == a))
            dup = 1;
        end
        r = '{kind: KIND_DECLARE, status: DECL_ADDED, partner: '0, index: '0, last: 1'b1};
        if (dup) begin
          r.status = DECL_PRESENT;
          n_present++;
        end else if (count >= DEPTH) begin
          r.status = DECL_FULL;
          n_full++;
        end else begin
          first_tab[count]  = a;
          second_tab[count] = b;
          count++;
          n_added++;
        end
        pending_results.push_back(r);
      end else begin
        n_find++;
        cap   = (lim > FOUND_CAP) ? FOUND_CAP : lim;
        found = 0;
        for (int i = 0; i < count && found < cap; i++) begin
          if (first_tab[i] == a)
            partner = second_tab[i];
          else if (second_tab[i] == a)
            partner = first_tab[i];
          else
            continue;
          found++;
          r = '{kind: KIND_PARTNER, status: DECL_ADDED, partner: partner,
                index: 7'(found), last: 1'b0};
          pending_results.push_back(r);
        end
        if (found == 0) begin
          r = '{kind: KIND_EMPTY, status: DECL_ADDED, partner: '0, index: '0, last: 1'b1};
          pending_results.push_back(r);
        end else begin
          r = pending_results.pop_back();
          r.last = 1'b1;
          pending_results.push_back(r);
        end
      end
    endfunction

    // 4-state compare so an unknown output bit counts as a mismatch
    function void field_check(string name, logic [31:0] exp, logic [31:0] act);
      if (exp !== act) begin
        $display("%0t: %s mismatch, expected %0h got %0h", $time, name, exp, act);
        n_errors++;
      end
    endfunction

    function void check_result(pair_result_t got);
      pair_result_t exp;
      n_checked++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected word, expected none got %p", $time, got);
        n_errors++;
        return;
      end
      exp = pending_results.pop_front();
      field_check("kind",        exp.kind,    got.kind);
      field_check("status",      exp.status,  got.status);
      field_check("partner_id",  exp.partner, got.partner);
      field_check("match_index", exp.index,   got.index);
      field_check("last",        exp.last,    got.last);
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;

  pair_scoreboard sb = new();
  bit             gaps_on;
  bit             hold_req;
  int             burst_left;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  symmetric_pair_table_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),   // first_id, second_id, result_limit, pad
    .s_axis_tuser  (s_tuser),   // cmd
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),   // status, partner_id, match_index, pad
    .m_axis_tuser  (m_tuser),   // kind
    .m_axis_tlast  (m_tlast)    // last
  );

  // Offer one word and hold it until taken; then maybe open a gap.
  task automatic send_item(cmd_e cmd, logic [15:0] a, logic [15:0] b, logic [6:0] lim);
    int gap;
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {1'b0, lim, b, a};
    do @(posedge clk_i); while (!s_tready);
    sb.note_item(cmd, a, b, lim);
    if (gaps_on) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        gap        = $urandom_range(1, 6);
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic drain_wait();
    s_tvalid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  function automatic logic [15:0] rand_id();
    return 16'($urandom());
  endfunction

  initial begin : stim
    int          n;
    int          r;
    int          idx;
    logic [15:0] a, b, t;
    logic [6:0]  lim;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    gaps_on = 1;

    // empty table, swapped duplicate, self pair, limit edges
    send_item(CMD_FIND,    16'h1234, rand_id(), 7'd5);
    send_item(CMD_DECLARE, 16'h0000, 16'hFFFF, 7'($urandom()));
    send_item(CMD_DECLARE, 16'hFFFF, 16'h0000, 7'($urandom()));
    send_item(CMD_DECLARE, 16'h0000, 16'hFFFF, 7'($urandom()));
    send_item(CMD_DECLARE, 16'h0007, 16'h0007, 7'($urandom()));
    send_item(CMD_DECLARE, 16'h0007, 16'h0007, 7'($urandom()));
    send_item(CMD_DECLARE, 16'h0007, 16'h8000, 7'($urandom()));
    send_item(CMD_DECLARE, 16'h1111, 16'h0007, 7'($urandom()));
    send_item(CMD_FIND,    16'h0007, rand_id(), 7'd64);
    send_item(CMD_FIND,    16'h0007, rand_id(), 7'd2);
    send_item(CMD_FIND,    16'h0007, rand_id(), 7'd0);
    send_item(CMD_FIND,    16'h0007, rand_id(), 7'd127);
    send_item(CMD_FIND,    16'hFFFF, rand_id(), 7'd1);
    send_item(CMD_FIND,    16'h0000, rand_id(), 7'd100);
    send_item(CMD_DECLARE, 16'hAAAA, 16'h5555, 7'd127);
    send_item(CMD_FIND,    16'h5555, 16'hFFFF, 7'd64);
    send_item(CMD_FIND,    16'h2222, 16'h0000, 7'd64);
    send_item(CMD_FIND,    16'h8000, rand_id(), 7'd1);
    drain_wait();

    n = 0;
    while (n < RANDOM_ITEMS || sb.n_full < 4) begin
      if (n % 50 == 0) gaps_on = ($urandom_range(0, 2) != 0);
      if (n == 100 || n == 300) drain_wait();
      if (n == 150 || n == 320) begin
        // hub find with many partners while the output is held off
        hold_req = 1;
        send_item(CMD_FIND, HUB_ID, rand_id(), 7'd64);
        n++;
        continue;
      end
      r   = $urandom_range(0, 99);
      lim = 7'($urandom());
      if (r < ((sb.count < DEPTH) ? 80 : 50)) begin
        if (sb.count > 0 && $urandom_range(0, 99) < 15) begin
          idx = $urandom_range(0, sb.count - 1);
          a   = sb.first_tab[idx];
          b   = sb.second_tab[idx];
        end else begin
          r = $urandom_range(0, 99);
          if (r < 30) begin
            a = HUB_ID;
            b = rand_id();
          end else if (r < 60) begin
            a = 16'($urandom_range(0, 47));
            b = 16'($urandom_range(0, 47));
          end else begin
            a = rand_id();
            b = rand_id();
          end
        end
        if ($urandom_range(0, 1)) begin
          t = a;
          a = b;
          b = t;
        end
        send_item(CMD_DECLARE, a, b, lim);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 30) begin
          a = HUB_ID;
        end else if (r < 70 && sb.count > 0) begin
          idx = $urandom_range(0, sb.count - 1);
          a   = $urandom_range(0, 1) ? sb.first_tab[idx] : sb.second_tab[idx];
        end else begin
          a = rand_id();
        end
        r = $urandom_range(0, 99);
        if (r < 10)      lim = 7'd0;
        else if (r < 20) lim = 7'd64;
        else if (r < 30) lim = 7'($urandom_range(0, 64));
        else             lim = 7'($urandom_range(1, 8));
        send_item(CMD_FIND, a, rand_id(), lim);
      end
      n++;
    end

    drain_wait();
    repeat (300) @(posedge clk_i);
    $display("Ran %0d declares (%0d added, %0d present, %0d on a full table) and %0d finds,",
             sb.n_added + sb.n_present + sb.n_full, sb.n_added, sb.n_present, sb.n_full,
             sb.n_find);
    $display("with %0d output words checked and %0d mismatches.", sb.n_checked, sb.n_errors);
    if (sb.n_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Output side: check each taken word, then pick tready for the next cycle.
  initial begin : rx
    int           cyc;
    int           hold_left;
    int           rx_mode;
    pair_result_t got;
    cyc       = 0;
    hold_left = 0;
    rx_mode   = 0;
    forever begin
      @(posedge clk_i);
      if (m_tvalid && m_tready) begin
        got.kind    = kind_e'(m_tuser);
        got.status  = decl_status_e'(m_tdata[1:0]);
        got.partner = m_tdata[17:2];
        got.index   = m_tdata[24:18];
        got.last    = m_tlast;
        sb.check_result(got);
      end
      cyc++;
      if (cyc % 64 == 0) rx_mode = $urandom_range(0, 3);
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (hold_req) begin
        hold_req  = 0;
        hold_left = LONG_HOLD;
        m_tready <= 1'b0;
      end else begin
        case (rx_mode)
          0: m_tready <= 1'b1;
          1: m_tready <= 1'($urandom_range(0, 1));
          2: m_tready <= ($urandom_range(0, 3) == 0);
          default: m_tready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

endmodule
